>>> rtl/core/mdp_pkg.sv
// magnus dew point package: fixed-point constants, widths, state and status codes
// and the request/response structs between the sequencer and the divider
// no dependencies
`timescale 1ns / 1ps

package mdp_pkg;

  localparam int READING_WIDTH = 16;
  localparam int DEW_W         = 16;

  // log2 datapath
  localparam int HUM_W     = 14;   // humidity in range fits 14 bits
  localparam int EXP_W     = 4;
  localparam int FRAC_W    = 20;
  localparam int MANT_W    = 31;
  localparam int CNT_W     = 5;
  localparam int LOG_W     = EXP_W + FRAC_W;
  localparam int LN_W      = 26;

  // shared multiplier
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;

  // divider
  localparam int DIV_UN_W  = 58;
  localparam int DIV_UD_W  = 45;
  localparam int DIV_Q_W   = 41;
  localparam int DIV_R_W   = 42;
  localparam int DIV_SAT_SHIFT = 40;

  localparam int ALPHA_W   = 43;
  localparam int TD_DEN_W  = 44;

  // magnus constants, hundredths and q20
  localparam int MAGNUS_A_Q20   = 18481152;
  localparam int MAGNUS_B_HUND  = 24304;
  localparam int LOG2_10K_Q20   = 13933176;
  localparam int LN2_Q20        = 726817;
  localparam int TERM_COEF      = 141;
  localparam int TERM_SHIFT     = 17;
  localparam int HUM_MAX        = 10000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_LOG_NORM,
    CS_LOG_MUL,
    CS_LOG_CHK,
    CS_LN_MUL,
    CS_LN_RND,
    CS_TERM_MUL,
    CS_TERM_DIV,
    CS_TERM_WAIT,
    CS_ALPHA,
    CS_TD_MUL_LO,
    CS_TD_MUL_HI,
    CS_TD_DIV,
    CS_TD_WAIT,
    CS_DONE
  } core_state_t;

  typedef struct packed {
    logic                start;
    logic                neg;
    logic [DIV_UN_W-1:0] un;
    logic [DIV_UD_W-1:0] ud;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [DIV_R_W-1:0]  q;
  } div_rsp_t;

endpackage

>>> rtl/core/magnus_dew_point.sv
// magnus dew point top level: reading store, status check, output register
// depends on mdp_pkg, mdp_core, mdp_div
`timescale 1ns / 1ps

// usage
// - input channel (in_valid/in_ready): one word carries mode, reading, reading_ok;
//   mode 0 updates the stored temperature, mode 1 the stored humidity; reading_ok
//   low marks that kind absent and clears its value
// - every accepted word yields exactly one output word (dew_temp, status) on
//   out_valid/out_ready; dew_temp is signed hundredths of a degree, status 0 ok,
//   1 a reading missing, 2 humidity outside (0, 100.00]; dew_temp is 0 when
//   status is nonzero
// - a word with nonzero status skips the computation; otherwise the result
//   is set by 20 squaring steps on the shared multiplier and two passes of
//   the 41-step bit-serial divider, which skips its steps when its numerator
//   is zero or it saturates
// - the block takes one word at a time; in_ready is high only while the
//   sequencer is idle
// - the output register frees the sequencer: a new word is taken while a
//   finished result still waits on a stalled receiver, and the next result
//   waits in the sequencer, with in_ready low, until the register drains
// - reset clears both stored readings and marks them absent, and empties the
//   output register

module magnus_dew_point #(
  parameter int READING_WIDTH = mdp_pkg::READING_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [READING_WIDTH-1:0]   reading,
  input  logic                              reading_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mdp_pkg::DEW_W-1:0]  dew_temp,
  output logic [1:0]                        status
);

  localparam int CMP_W = 33;

  // stored readings
  logic signed [READING_WIDTH-1:0] last_temperature, last_temperature_next;
  logic signed [READING_WIDTH-1:0] last_humidity, last_humidity_next;
  logic                            temperature_present, temperature_present_next;
  logic                            humidity_present, humidity_present_next;

  logic                            in_fire;
  logic signed [READING_WIDTH-1:0] value;
  logic signed [CMP_W-1:0]         hum_ext;
  mdp_pkg::status_t                st_new;

  logic                              core_ready, core_done, core_take;
  logic signed [mdp_pkg::DEW_W-1:0]  core_dew;
  mdp_pkg::status_t                  core_status;

  assign in_fire = in_valid && in_ready;
  assign value   = reading_ok ? reading : '0;

  // the selected kind takes the new word, the other keeps its value
  always_comb begin
    last_temperature_next    = last_temperature;
    temperature_present_next = temperature_present;
    last_humidity_next       = last_humidity;
    humidity_present_next    = humidity_present;
    if (mode) begin
      last_humidity_next    = value;
      humidity_present_next = reading_ok;
    end else begin
      last_temperature_next    = value;
      temperature_present_next = reading_ok;
    end
  end

  // missing reading wins over the range check
  assign hum_ext = CMP_W'(last_humidity_next);
  always_comb begin
    if (!temperature_present_next || !humidity_present_next) begin
      st_new = mdp_pkg::ST_MISSING;
    end else if (hum_ext <= 0 || hum_ext > CMP_W'(mdp_pkg::HUM_MAX)) begin
      st_new = mdp_pkg::ST_RANGE;
    end else begin
      st_new = mdp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temperature    <= '0;
      temperature_present <= 1'b0;
      last_humidity       <= '0;
      humidity_present    <= 1'b0;
    end else if (in_fire) begin
      last_temperature    <= last_temperature_next;
      temperature_present <= temperature_present_next;
      last_humidity       <= last_humidity_next;
      humidity_present    <= humidity_present_next;
    end
  end

  mdp_core #(
    .READING_WIDTH (READING_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (in_fire),
    .temp       (last_temperature_next),
    .hum        (hum_ext[mdp_pkg::HUM_W-1:0]),
    .status_in  (st_new),
    .ready      (core_ready),
    .done       (core_done),
    .take       (core_take),
    .dew        (core_dew),
    .status_out (core_status)
  );

  assign in_ready = core_ready;

  // output register, loads when empty or draining
  assign core_take = core_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      dew_temp <= core_dew;
      status   <= core_status;
    end
  end

  // a taken word leaves the sequencer busy in the cycle after
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("sequencer ready right after taking a word");

  // a failed status never carries a dew point
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mdp_pkg::ST_OK |-> dew_temp == '0)
    else $error("nonzero dew point with error status");

  // a finished result never coexists with an idle sequencer
  assert property (@(posedge clk) disable iff (rst)
    core_done |-> !in_ready)
    else $error("sequencer idle while holding a result");

  // a result is only handed over into a free or draining register
  assert property (@(posedge clk) disable iff (rst)
    core_take |-> !out_valid || out_ready)
    else $error("output register overwritten");

endmodule

>>> rtl/core/mdp_div.sv
// restoring divider, one quotient bit a cycle, rounds half away from zero
// and saturates the magnitude to 2^40; depends on mdp_pkg
`timescale 1ns / 1ps

module mdp_div (
  input  logic              clk,
  input  logic              rst,
  input  mdp_pkg::div_req_t req,
  output mdp_pkg::div_rsp_t rsp
);

  localparam int N_W  = mdp_pkg::DIV_UN_W + 2;
  localparam int D2_W = mdp_pkg::DIV_UD_W + 1;
  localparam int R_W  = D2_W + 1;
  localparam int Q_W  = mdp_pkg::DIV_Q_W;
  localparam int HI_W = N_W - Q_W;
  localparam int C_W  = $clog2(Q_W + 1);

  logic [N_W-1:0]  num;
  logic [D2_W-1:0] den2;
  logic [D2_W-1:0] den2_r;
  logic [HI_W-1:0] num_hi;
  logic            sat_hit;
  logic [R_W-1:0]  trial;
  logic            fits;
  logic [Q_W-1:0]  q_mag;

  logic                              busy;
  logic [C_W-1:0]                    cnt;
  logic [R_W-1:0]                    rem;
  logic [Q_W-1:0]                    lo;
  logic [Q_W-1:0]                    qacc;
  logic                              neg;
  logic                              done;
  logic signed [mdp_pkg::DIV_R_W-1:0] result;

  localparam logic [Q_W-1:0] SAT_MAG = Q_W'(1) << mdp_pkg::DIV_SAT_SHIFT;

  // rounded quotient: (2n + d) / (2d)
  assign num     = {1'b0, req.un, 1'b0} + N_W'(req.ud);
  assign den2    = {req.ud, 1'b0};
  assign num_hi  = num[N_W-1:Q_W];
  assign sat_hit = D2_W'(num_hi) >= den2;

  assign trial = {rem[R_W-2:0], lo[Q_W-1]};
  assign fits  = trial >= R_W'(den2_r);

  always_comb begin
    q_mag = {qacc[Q_W-2:0], fits};
    if (q_mag > SAT_MAG) begin
      q_mag = SAT_MAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg    <= req.neg;
        den2_r <= den2;
        if (req.un == '0) begin
          result <= '0;
          done   <= 1'b1;
        end else if (sat_hit) begin
          result <= req.neg ? -$signed({1'b0, SAT_MAG}) : $signed({1'b0, SAT_MAG});
          done   <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          rem  <= R_W'(num_hi);
          lo   <= num[Q_W-1:0];
          qacc <= '0;
        end
      end else if (busy) begin
        rem  <= fits ? trial - R_W'(den2_r) : trial;
        lo   <= {lo[Q_W-2:0], 1'b0};
        qacc <= {qacc[Q_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == C_W'(Q_W - 1)) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = result;

endmodule

>>> rtl/core/mdp_core.sv
// dew point sequencer: log2 by repeated squaring, ln scaling, magnus term and
// final division over one shared multiplier and one divider; depends on mdp_pkg, mdp_div
`timescale 1ns / 1ps

module mdp_core #(
  parameter int READING_WIDTH = mdp_pkg::READING_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [READING_WIDTH-1:0]   temp,
  input  logic [mdp_pkg::HUM_W-1:0]         hum,
  input  mdp_pkg::status_t                  status_in,
  output logic                              ready,
  output logic                              done,
  input  logic                              take,
  output logic signed [mdp_pkg::DEW_W-1:0]  dew,
  output mdp_pkg::status_t                  status_out
);

  localparam int T_W   = 33;
  localparam int DEN_W = 34;

  mdp_pkg::core_state_t state, state_next;

  logic signed [READING_WIDTH-1:0]       temp_r;
  logic [mdp_pkg::HUM_W-1:0]             hum_r;
  mdp_pkg::status_t                      st_r;
  logic [mdp_pkg::MANT_W-1:0]            m;
  logic [mdp_pkg::EXP_W-1:0]             e;
  logic [mdp_pkg::FRAC_W-1:0]            frac;
  logic [mdp_pkg::CNT_W-1:0]             cnt;
  logic [mdp_pkg::PROD_W-1:0]            prod;
  logic signed [mdp_pkg::LN_W-1:0]       ln;
  logic signed [mdp_pkg::DIV_R_W-1:0]    term;
  logic signed [mdp_pkg::ALPHA_W-1:0]    alpha;
  logic [mdp_pkg::DIV_UN_W-1:0]          acc;
  logic signed [mdp_pkg::DEW_W-1:0]      dew_r;

  logic [mdp_pkg::MUL_W-1:0]  mul_a, mul_b;
  mdp_pkg::div_req_t          div_req;
  mdp_pkg::div_rsp_t          div_rsp;

  // leading one and normalized mantissa
  logic [mdp_pkg::EXP_W-1:0]  lead;
  logic [mdp_pkg::MANT_W-1:0] norm_m;
  always_comb begin
    lead = '0;
    for (int i = 0; i < mdp_pkg::HUM_W; i++) begin
      if (hum_r[i]) begin
        lead = mdp_pkg::EXP_W'(i);
      end
    end
    norm_m = mdp_pkg::MANT_W'(hum_r) << (5'(mdp_pkg::MANT_W - 1) - 5'(lead));
  end

  logic [31:0] sq;
  logic [mdp_pkg::CNT_W-1:0] frac_idx;
  assign sq       = prod[61:30];
  assign frac_idx = mdp_pkg::CNT_W'(mdp_pkg::FRAC_W - 1) - cnt;

  // log2 minus log2(10000), q20
  logic signed [mdp_pkg::LN_W-1:0] diff;
  logic [mdp_pkg::LN_W-1:0]        diff_mag;
  logic [mdp_pkg::LN_W-1:0]        ln_mag;
  assign diff     = $signed({2'b00, e, frac}) - mdp_pkg::LN_W'(mdp_pkg::LOG2_10K_Q20);
  assign diff_mag = diff[mdp_pkg::LN_W-1] ? -diff : diff;
  assign ln_mag   = mdp_pkg::LN_W'((prod[45:0] + 46'(1 << 19)) >> 20);

  // temperature term operands
  logic signed [T_W-1:0]   t_ext;
  logic [T_W-1:0]          t_mag;
  logic signed [DEN_W-1:0] t_den;
  logic [DEN_W-1:0]        t_den_mag;
  assign t_ext     = T_W'(temp_r);
  assign t_mag     = t_ext[T_W-1] ? -t_ext : t_ext;
  assign t_den     = DEN_W'(t_ext) + DEN_W'(mdp_pkg::MAGNUS_B_HUND);
  assign t_den_mag = t_den[DEN_W-1] ? -t_den : t_den;

  // final division operands
  logic [mdp_pkg::ALPHA_W-1:0]           a_mag;
  logic signed [mdp_pkg::TD_DEN_W-1:0]   td_den;
  logic [mdp_pkg::TD_DEN_W-1:0]          td_den_mag;
  assign a_mag      = alpha[mdp_pkg::ALPHA_W-1] ? -alpha : alpha;
  assign td_den     = mdp_pkg::TD_DEN_W'(mdp_pkg::MAGNUS_A_Q20)
                      - mdp_pkg::TD_DEN_W'(alpha);
  assign td_den_mag = td_den[mdp_pkg::TD_DEN_W-1] ? -td_den : td_den;

  // saturate the dew point
  logic signed [mdp_pkg::DEW_W-1:0] td_sat;
  always_comb begin
    if (div_rsp.q > mdp_pkg::DIV_R_W'(32767)) begin
      td_sat = 16'sh7fff;
    end else if (div_rsp.q < -mdp_pkg::DIV_R_W'(32768)) begin
      td_sat = -16'sh8000;
    end else begin
      td_sat = div_rsp.q[mdp_pkg::DEW_W-1:0];
    end
  end

  mdp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mdp_pkg::CS_IDLE:
        if (start) begin
          state_next = (status_in != mdp_pkg::ST_OK) ? mdp_pkg::CS_DONE : mdp_pkg::CS_LOG_NORM;
        end
      mdp_pkg::CS_LOG_NORM:  state_next = mdp_pkg::CS_LOG_MUL;
      mdp_pkg::CS_LOG_MUL:   state_next = mdp_pkg::CS_LOG_CHK;
      mdp_pkg::CS_LOG_CHK:
        state_next = (cnt == mdp_pkg::CNT_W'(mdp_pkg::FRAC_W - 1)) ?
                     mdp_pkg::CS_LN_MUL : mdp_pkg::CS_LOG_MUL;
      mdp_pkg::CS_LN_MUL:    state_next = mdp_pkg::CS_LN_RND;
      mdp_pkg::CS_LN_RND:    state_next = mdp_pkg::CS_TERM_MUL;
      mdp_pkg::CS_TERM_MUL:  state_next = mdp_pkg::CS_TERM_DIV;
      mdp_pkg::CS_TERM_DIV:  state_next = mdp_pkg::CS_TERM_WAIT;
      mdp_pkg::CS_TERM_WAIT: if (div_rsp.done) state_next = mdp_pkg::CS_ALPHA;
      mdp_pkg::CS_ALPHA:     state_next = mdp_pkg::CS_TD_MUL_LO;
      mdp_pkg::CS_TD_MUL_LO: state_next = mdp_pkg::CS_TD_MUL_HI;
      mdp_pkg::CS_TD_MUL_HI: state_next = mdp_pkg::CS_TD_DIV;
      mdp_pkg::CS_TD_DIV:    state_next = mdp_pkg::CS_TD_WAIT;
      mdp_pkg::CS_TD_WAIT:   if (div_rsp.done) state_next = mdp_pkg::CS_DONE;
      mdp_pkg::CS_DONE:      if (take) state_next = mdp_pkg::CS_IDLE;
      default:               state_next = mdp_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;
    unique case (state)
      mdp_pkg::CS_LOG_MUL: begin
        mul_a = mdp_pkg::MUL_W'(m);
        mul_b = mdp_pkg::MUL_W'(m);
      end
      mdp_pkg::CS_LN_MUL: begin
        mul_a = mdp_pkg::MUL_W'(diff_mag);
        mul_b = mdp_pkg::MUL_W'(mdp_pkg::LN2_Q20);
      end
      mdp_pkg::CS_TERM_MUL: begin
        mul_a = t_mag[mdp_pkg::MUL_W-1:0];
        mul_b = mdp_pkg::MUL_W'(mdp_pkg::TERM_COEF);
      end
      mdp_pkg::CS_TERM_DIV: begin
        div_req.start = 1'b1;
        div_req.neg   = t_ext[T_W-1] ^ t_den[DEN_W-1];
        div_req.un    = {prod[40:0], 17'b0};
        div_req.ud    = mdp_pkg::DIV_UD_W'(t_den_mag);
      end
      mdp_pkg::CS_TD_MUL_LO: begin
        mul_a = a_mag[31:0];
        mul_b = mdp_pkg::MUL_W'(mdp_pkg::MAGNUS_B_HUND);
      end
      mdp_pkg::CS_TD_MUL_HI: begin
        mul_a = mdp_pkg::MUL_W'(a_mag[mdp_pkg::ALPHA_W-1:32]);
        mul_b = mdp_pkg::MUL_W'(mdp_pkg::MAGNUS_B_HUND);
      end
      mdp_pkg::CS_TD_DIV: begin
        div_req.start = 1'b1;
        div_req.neg   = alpha[mdp_pkg::ALPHA_W-1] ^ td_den[mdp_pkg::TD_DEN_W-1];
        div_req.un    = acc + {prod[25:0], 32'b0};
        div_req.ud    = mdp_pkg::DIV_UD_W'(td_den_mag);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdp_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      mdp_pkg::CS_IDLE:
        if (start) begin
          temp_r <= temp;
          hum_r  <= hum;
          st_r   <= status_in;
          dew_r  <= '0;
        end
      mdp_pkg::CS_LOG_NORM: begin
        m    <= norm_m;
        e    <= lead;
        frac <= '0;
        cnt  <= '0;
      end
      mdp_pkg::CS_LOG_CHK: begin
        if (sq[31]) begin
          m              <= sq[31:1];
          frac[frac_idx] <= 1'b1;
        end else begin
          m <= sq[30:0];
        end
        cnt <= cnt + 1'b1;
      end
      mdp_pkg::CS_LN_RND:    ln <= diff[mdp_pkg::LN_W-1] ? -$signed(ln_mag) : $signed(ln_mag);
      mdp_pkg::CS_TERM_WAIT: if (div_rsp.done) term <= div_rsp.q;
      mdp_pkg::CS_ALPHA:
        alpha <= mdp_pkg::ALPHA_W'(ln) + mdp_pkg::ALPHA_W'(term);
      mdp_pkg::CS_TD_MUL_HI: acc <= mdp_pkg::DIV_UN_W'(prod);
      mdp_pkg::CS_TD_WAIT:   if (div_rsp.done) dew_r <= td_sat;
      default: begin
      end
    endcase
  end

  assign ready      = (state == mdp_pkg::CS_IDLE);
  assign done       = (state == mdp_pkg::CS_DONE);
  assign dew        = dew_r;
  assign status_out = st_r;

endmodule

>>> tb/sv/dew_point_checker.sv
// dew point checker: watches both channels, predicts each result word and compares
// depends on mdp_pkg
`timescale 1ns / 1ps

module dew_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic signed [15:0] reading,
  input  logic               reading_ok,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] dew_temp,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] dew;
    mdp_pkg::status_t   st;
  } dew_word_t;

  dew_word_t expected_words[$];
  longint    temp_hund, hum_hund;
  bit        temp_seen, hum_seen;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint un, ud, q;
    bit     neg;
    neg = (n < 0) != (d < 0);
    un  = mag(n);
    ud  = mag(d);
    if (un == 0) return 0;
    if (ud == 0) q = 64'sd1 <<< 40;
    else begin
      q = (2 * un + ud) / (2 * ud);
      if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    end
    return neg ? -q : q;
  endfunction

  function automatic longint log2_fixed(longint h);
    int      e;
    longint  m, frac;
    e    = 0;
    frac = 0;
    while (e < 31 && (h >>> (e + 1)) != 0) e++;
    m = h <<< (30 - e);
    for (int i = 1; i <= 20; i++) begin
      m = (m * m) >>> 30;
      if (m >= (64'sd1 <<< 31)) begin
        m = m >>> 1;
        frac = frac | (64'sd1 <<< (20 - i));
      end
    end
    return (longint'(e) <<< 20) + frac;
  endfunction

  function automatic dew_word_t dew_for_update(bit is_hum, bit ok, logic signed [15:0] r);
    dew_word_t w;
    longint    v, ln_q, term_q, alpha, td;
    v = ok ? longint'(r) : 0;
    if (is_hum) begin
      hum_hund = v;
      hum_seen = ok;
    end else begin
      temp_hund = v;
      temp_seen = ok;
    end
    w.dew = '0;
    if (!temp_seen || !hum_seen) w.st = mdp_pkg::ST_MISSING;
    else if (hum_hund <= 0 || hum_hund > mdp_pkg::HUM_MAX) w.st = mdp_pkg::ST_RANGE;
    else begin
      ln_q   = div_round((log2_fixed(hum_hund) - mdp_pkg::LOG2_10K_Q20) * mdp_pkg::LN2_Q20,
                         64'sd1 <<< 20);
      term_q = div_round(temp_hund * mdp_pkg::TERM_COEF * (64'sd1 <<< mdp_pkg::TERM_SHIFT),
                         mdp_pkg::MAGNUS_B_HUND + temp_hund);
      alpha  = ln_q + term_q;
      td     = div_round(alpha * mdp_pkg::MAGNUS_B_HUND, mdp_pkg::MAGNUS_A_Q20 - alpha);
      if (td > 32767) td = 32767;
      if (td < -32768) td = -32768;
      w.dew = td[15:0];
      w.st  = mdp_pkg::ST_OK;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dew_word_t w;
    if (rst) begin
      temp_hund  = 0;
      hum_hund   = 0;
      temp_seen  = 0;
      hum_seen   = 0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(dew_for_update(mode, reading_ok, reading));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) report_mismatch("unexpected word", dew_temp, 0);
        else begin
          w = expected_words.pop_front();
          if (dew_temp !== w.dew) report_mismatch("dew_temp", dew_temp, w.dew);
          if (status !== w.st) report_mismatch("status", status, w.st);
        end
      end
    end
    pending = expected_words.size();
  end
endmodule

>>> tb/sv/tb.sv
// testbench top: drives reading words into the dew point block, stalls the receiver
// depends on mdp_pkg, magnus_dew_point, dew_checker
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 20000;  // idle cycles with no handshake before giving up
  localparam int RANDOM_WORDS = 500;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic               mode = 0;
  logic signed [15:0] reading = '0;
  logic               reading_ok = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [15:0] dew_temp;
  logic [1:0]         status;
  int                 fail_count, pending;
  int                 idle_cycles = 0;
  bit                 calm = 0;        // final stretch: no idling on either side
  bit                 long_hold = 0;   // receiver holds off to back up the block
  bit                 hold_done = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  magnus_dew_point u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .reading(reading), .reading_ok(reading_ok),
    .out_valid(out_valid), .out_ready(out_ready),
    .dew_temp(dew_temp), .status(status)
  );

  dew_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .reading(reading), .reading_ok(reading_ok),
    .out_valid(out_valid), .out_ready(out_ready),
    .dew_temp(dew_temp), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog: cycles with no accepted word on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        hold_done = 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  // one word; waits for acceptance, valid stays high across back-to-back words
  task automatic send_word(bit m, logic signed [15:0] r, bit ok);
    mode       <= m;
    reading    <= r;
    reading_ok <= ok;
    in_valid   <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // humidity mostly in range, sometimes anywhere
  function automatic logic signed [15:0] pick_humidity();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 2) == 0 ? 16'sd10000 : 16'sd1;
      default: return 16'($urandom_range(1, 10000));
    endcase
  endfunction

  // temperature mostly physical, sometimes any 16-bit value or the pole
  function automatic logic signed [15:0] pick_temperature();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return -16'sd24304;
      default: return $signed(16'($urandom_range(0, 12000))) - 16'sd4000;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: missing readings, extremes, range edges, zero divisors
    send_word(1, 16'sd5000, 1);     // temperature still missing
    send_word(0, 16'sd2000, 1);
    send_word(1, 16'sd10000, 1);
    send_word(1, 16'sd1, 1);
    send_word(1, 16'sd10001, 1);    // out of range
    send_word(1, 16'sd0, 1);
    send_word(1, -16'sd32768, 1);
    send_word(1, 16'sd32767, 1);
    send_word(1, 16'sd5000, 0);     // invalid humidity
    send_word(1, 16'sd5000, 1);
    send_word(0, 16'sd1234, 0);     // invalid temperature, missing wins
    send_word(1, 16'sd0, 1);
    send_word(0, -16'sd24304, 1);   // zero divisor in the term
    send_word(1, 16'sd5000, 1);
    send_word(0, 16'sd32767, 1);
    send_word(0, -16'sd32768, 1);
    send_word(0, -16'sd24303, 1);
    send_word(0, -16'sd24305, 1);
    send_word(0, 16'sd0, 1);
    send_word(1, 16'sd100, 1);
    send_word(0, -16'sd1, 1);
    send_word(1, 16'sd9999, 1);

    // long receiver hold while words keep coming
    long_hold = 1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      bit m;
      if (i == RANDOM_WORDS * 4 / 5) calm = 1;
      m = $urandom_range(0, 1);
      send_word(m, m ? pick_humidity() : pick_temperature(), $urandom_range(0, 15) != 0);
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
